// ----- hdl/doubly_linked_list_manager_defines.svh -----
// assertion macros for the linked list manager checker
// no dependencies; included by the checker file only
`ifndef DOUBLY_LINKED_LIST_MANAGER_DEFINES_SVH
`define DOUBLY_LINKED_LIST_MANAGER_DEFINES_SVH

// property checked on every rising edge while out of reset
`define DLLM_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define DLLM_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/dllm_pkg.sv -----
// shared types and codes for the linked list manager
// no dependencies
`default_nettype none

package dllm_pkg;

	localparam int MAX_RESULTS = 32;

	typedef enum logic [1:0] {
		ACT_INS_HEAD = 2'd0,
		ACT_INS_TAIL = 2'd1,
		ACT_DELETE   = 2'd2,
		ACT_TRAVERSE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DELETED   = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_FULL      = 3'd4,
		ST_ELEMENT   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK
	} state_t;

	typedef struct packed {
		logic write;
		logic shift_left;
		logic shift_right;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/dllm_cell.sv -----
// one list cell: holds one value, takes it from a neighbor or the write bus
// depends on dllm_pkg
`default_nettype none

module dllm_cell (
	input  wire logic               clk,
	input  wire dllm_pkg::cell_ctl_t ctl,
	input  wire logic               sel,
	input  wire logic signed [31:0] left_value,
	input  wire logic signed [31:0] right_value,
	input  wire logic signed [31:0] wr_value,
	output logic signed [31:0]      value
);

	logic signed [31:0] value_q;

	always_ff @(posedge clk) begin
		priority if (ctl.write && sel) begin
			value_q <= wr_value;
		end else if (ctl.shift_left) begin
			value_q <= right_value;
		end else if (ctl.shift_right) begin
			value_q <= left_value;
		end else begin
			value_q <= value_q;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire

// ----- hdl/dllm_chain.sv -----
// row of list cells, position 0 is the head of the list
// depends on dllm_pkg and dllm_cell
`default_nettype none

module dllm_chain #(
	parameter int CAPACITY = 32
) (
	input  wire logic                        clk,
	input  wire dllm_pkg::cell_ctl_t         ctl,
	input  wire logic [$clog2(CAPACITY)-1:0] wr_pos,
	input  wire logic signed [31:0]          wr_value,
	output logic signed [31:0]               head_value
);

	localparam int IW = $clog2(CAPACITY);

	logic signed [31:0] cell_value [CAPACITY];
	logic signed [31:0] left_v     [CAPACITY];
	logic signed [31:0] right_v    [CAPACITY];
	logic               sel        [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign sel[i] = (wr_pos == IW'(i));

		if (i == 0) begin : g_first
			assign left_v[i] = wr_value;
		end else begin : g_mid_l
			assign left_v[i] = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v[i] = wr_value;
		end else begin : g_mid_r
			assign right_v[i] = cell_value[i+1];
		end

		dllm_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.sel         (sel[i]),
			.left_value  (left_v[i]),
			.right_value (right_v[i]),
			.wr_value    (wr_value),
			.value       (cell_value[i])
		);
	end

	assign head_value = cell_value[0];

endmodule

`default_nettype wire

// ----- hdl/doubly_linked_list_manager.sv -----
// channel | signals                     | payload
// input   | in_valid / in_ready         | action, value
// output  | out_valid / out_ready       | status, result_value, last
//
// insert: accepted in idle, then the result, and the chain update when not full,
//   are registered together in exec; delete and traverse: the chain rotates one
//   cell per cycle past the head while not stalled, so every list element is
//   visited once and the order is restored when the walk ends
// a result waiting on out_ready freezes the rotation; a new item is taken as
//   soon as the previous one has handed over its final result
// reset empties the list at once; cell contents are not cleared
// depends on dllm_pkg and dllm_chain
`default_nettype none

module doubly_linked_list_manager #(
	parameter int CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic signed [31:0]      result_value,
	output logic                    last
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	dllm_pkg::state_t    state_q, state_nxt;
	dllm_pkg::action_t   op_q;
	logic signed [31:0]  val_q;
	logic [CW-1:0]       count_q, count_nxt;
	logic [CW-1:0]       rem_q;
	logic [CW-1:0]       k_q;
	logic                found_q;

	logic                out_valid_q;
	dllm_pkg::status_t   status_q;
	logic signed [31:0]  result_value_q;
	logic                last_q;

	dllm_pkg::cell_ctl_t ctl;
	logic [CW-1:0]       pos_cw;
	logic signed [31:0]  wr_data;
	logic signed [31:0]  head_value;

	logic                can_emit;
	logic                emit;
	logic                fire;
	dllm_pkg::status_t   emit_status;
	logic signed [31:0]  emit_value;
	logic                emit_last;
	logic                exec_go;
	logic                walk_start;
	logic                walk_step;
	logic                walk_done;
	logic                drop;

	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = (state_q == dllm_pkg::S_IDLE);

	// control and result selection
	always_comb begin
		ctl         = '0;
		pos_cw      = '0;
		wr_data     = val_q;
		count_nxt   = count_q;
		emit        = 1'b0;
		emit_status = dllm_pkg::ST_INSERTED;
		emit_value  = val_q;
		emit_last   = 1'b1;
		exec_go     = 1'b0;
		walk_start  = 1'b0;
		walk_step   = 1'b0;
		walk_done   = 1'b0;
		drop        = 1'b0;

		unique case (state_q)
			dllm_pkg::S_IDLE: begin
			end
			dllm_pkg::S_EXEC: begin
				unique case (op_q)
					dllm_pkg::ACT_INS_HEAD, dllm_pkg::ACT_INS_TAIL: begin
						emit    = 1'b1;
						exec_go = can_emit;
						if (count_q == CW'(CAPACITY)) begin
							emit_status = dllm_pkg::ST_FULL;
						end else begin
							emit_status     = dllm_pkg::ST_INSERTED;
							ctl.write       = can_emit;
							ctl.shift_right = can_emit && (op_q == dllm_pkg::ACT_INS_HEAD);
							pos_cw          = (op_q == dllm_pkg::ACT_INS_HEAD) ? '0 : count_q;
							if (can_emit) begin
								count_nxt = count_q + 1'b1;
							end
						end
					end
					dllm_pkg::ACT_DELETE, dllm_pkg::ACT_TRAVERSE: begin
						if (count_q == '0) begin
							emit        = 1'b1;
							exec_go     = can_emit;
							emit_status = dllm_pkg::ST_EMPTY;
							emit_value  = (op_q == dllm_pkg::ACT_DELETE) ? val_q : 32'sd0;
						end else begin
							exec_go    = 1'b1;
							walk_start = 1'b1;
						end
					end
				endcase
			end
			dllm_pkg::S_WALK: begin
				if (op_q == dllm_pkg::ACT_TRAVERSE) begin
					emit        = (int'(k_q) < dllm_pkg::MAX_RESULTS);
					emit_status = dllm_pkg::ST_ELEMENT;
					emit_value  = head_value;
					emit_last   = (k_q == count_q - 1'b1) ||
					              (int'(k_q) == dllm_pkg::MAX_RESULTS - 1);
				end else begin
					drop        = !found_q && (head_value == val_q);
					emit        = (rem_q == CW'(1));
					emit_status = (found_q || drop) ? dllm_pkg::ST_DELETED
					                                : dllm_pkg::ST_NOT_FOUND;
					emit_value  = val_q;
					emit_last   = 1'b1;
				end
				walk_step = !emit || can_emit;
				walk_done = walk_step && (rem_q == CW'(1));
				if (walk_step) begin
					// head leaves, rest moves up, head rejoins at the tail unless dropped
					ctl.shift_left = 1'b1;
					ctl.write      = !drop;
					pos_cw         = count_q - 1'b1;
					wr_data        = head_value;
					if (drop) begin
						count_nxt = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign fire = emit && can_emit;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dllm_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = dllm_pkg::S_EXEC;
				end
			end
			dllm_pkg::S_EXEC: begin
				if (exec_go) begin
					state_nxt = walk_start ? dllm_pkg::S_WALK : dllm_pkg::S_IDLE;
				end
			end
			dllm_pkg::S_WALK: begin
				if (walk_done) begin
					state_nxt = dllm_pkg::S_IDLE;
				end
			end
			default: state_nxt = dllm_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dllm_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			k_q         <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (walk_start) begin
				rem_q   <= count_q;
				k_q     <= '0;
				found_q <= 1'b0;
			end else if (walk_step) begin
				rem_q   <= rem_q - 1'b1;
				k_q     <= k_q + 1'b1;
				found_q <= found_q || drop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= dllm_pkg::action_t'(action);
			val_q <= value;
		end
		if (fire) begin
			status_q       <= emit_status;
			result_value_q <= emit_value;
			last_q         <= emit_last;
		end
	end

	dllm_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk        (clk),
		.ctl        (ctl),
		.wr_pos     (pos_cw[IW-1:0]),
		.wr_value   (wr_data),
		.head_value (head_value)
	);

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_value_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// ----- hdl/dllm_checker.sv -----
// port-level checks for the linked list manager, bound to the top level
// depends on dllm_pkg and doubly_linked_list_manager_defines.svh
`default_nettype none
`include "doubly_linked_list_manager_defines.svh"

module dllm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [2:0]         status,
	input wire logic signed [31:0] result_value,
	input wire logic               last
);

	`DLLM_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_value) && $stable(last), "stalled result changed")
	`DLLM_ASSERT(a_status_code, clk, arst_n, out_valid |-> status <= dllm_pkg::ST_ELEMENT, "status code out of range")
	`DLLM_ASSERT(a_status_last, clk, arst_n, out_valid && status != dllm_pkg::ST_ELEMENT |-> last, "status result without last")
	`DLLM_ASSERT(a_one_item, clk, arst_n, in_valid && in_ready |=> !in_ready, "item taken while one is in work")
	`DLLM_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid, "result shown during reset")

endmodule

bind doubly_linked_list_manager dllm_checker u_dllm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.result_value (result_value),
	.last         (last)
);

`default_nettype wire

// ----- sim/doubly_linked_list_manager_tb.sv -----
// self-checking testbench for the doubly linked list manager
// keeps a value-level copy of the list to predict every status and element
// depends on dllm_pkg and doubly_linked_list_manager
`default_nettype none

module doubly_linked_list_manager_tb;

	localparam int DEPTH = 32;
	localparam int STALL_LIMIT = 4000;

	typedef struct {
		dllm_pkg::action_t  act;
		logic signed [31:0] val;
	} command_t;

	typedef struct {
		dllm_pkg::status_t  status;
		logic signed [31:0] val;
		logic               last;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = dllm_pkg::ACT_INS_HEAD;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic signed [31:0] result_value;
	logic last;

	command_t pending_commands[$];
	response_t expected_responses[$];
	logic signed [31:0] list_contents[$];
	logic signed [31:0] inserted_values[$];

	command_t next_command;
	response_t oldest;
	int send_gap = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int responses_checked = 0;
	int elements_seen = 0;
	int full_hits = 0;
	int deepest = 0;
	int commands_by_action[4] = '{0, 0, 0, 0};
	bit quiet = 1'b0;

	doubly_linked_list_manager #(.CAPACITY(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_value(result_value),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic expect_response(input dllm_pkg::status_t s,
			input logic signed [31:0] v, input logic l);
		response_t r;
		r.status = s;
		r.val = v;
		r.last = l;
		expected_responses.push_back(r);
	endtask

	// applies one command to the list copy and queues what the block should return
	task automatic apply_command(input dllm_pkg::action_t act,
			input logic signed [31:0] v);
		int found;
		int n;
		found = -1;
		case (act)
			dllm_pkg::ACT_INS_HEAD, dllm_pkg::ACT_INS_TAIL: begin
				if (list_contents.size() >= DEPTH) begin
					full_hits++;
					expect_response(dllm_pkg::ST_FULL, v, 1'b1);
				end else begin
					if (act == dllm_pkg::ACT_INS_HEAD)
						list_contents.push_front(v);
					else
						list_contents.push_back(v);
					if (list_contents.size() > deepest)
						deepest = list_contents.size();
					expect_response(dllm_pkg::ST_INSERTED, v, 1'b1);
				end
			end
			dllm_pkg::ACT_DELETE: begin
				if (list_contents.size() == 0) begin
					expect_response(dllm_pkg::ST_EMPTY, v, 1'b1);
				end else begin
					// only the match nearest the head goes
					for (int i = 0; i < list_contents.size(); i++)
						if (found < 0 && list_contents[i] == v)
							found = i;
					if (found < 0) begin
						expect_response(dllm_pkg::ST_NOT_FOUND, v, 1'b1);
					end else begin
						list_contents.delete(found);
						expect_response(dllm_pkg::ST_DELETED, v, 1'b1);
					end
				end
			end
			default: begin
				if (list_contents.size() == 0) begin
					expect_response(dllm_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					n = list_contents.size() > dllm_pkg::MAX_RESULTS ?
						dllm_pkg::MAX_RESULTS : list_contents.size();
					for (int i = 0; i < n; i++)
						expect_response(dllm_pkg::ST_ELEMENT, list_contents[i], i == n - 1);
				end
			end
		endcase
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= dllm_pkg::ACT_INS_HEAD;
			value <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_commands.size() > 0) begin
				next_command = pending_commands.pop_front();
				in_valid <= 1'b1;
				action <= next_command.act;
				value <= next_command.val;
				if (!quiet && $urandom_range(0, 4) == 0)
					send_gap <= $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: predicts on the input handshake, then checks the output handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				commands_by_action[action]++;
				apply_command(dllm_pkg::action_t'(action), value);
			end
			if (out_valid && out_ready) begin
				responses_checked++;
				if (expected_responses.size() == 0) begin
					$display("%0t: unexpected item: status %0d value %0d last %0b",
						$time, status, result_value, last);
					errors++;
				end else begin
					oldest = expected_responses.pop_front();
					if (oldest.status == dllm_pkg::ST_ELEMENT)
						elements_seen++;
					if (status !== oldest.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, oldest.status, status);
						errors++;
					end
					if (result_value !== oldest.val) begin
						$display("%0t: result_value expected %0d, got %0d",
							$time, oldest.val, result_value);
						errors++;
					end
					if (last !== oldest.last) begin
						$display("%0t: last expected %0b, got %0b",
							$time, oldest.last, last);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 4) == 0)
					stall_left <= $urandom_range(1, 10);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("doubly_linked_list_manager_tb: errors");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic queue_command(input dllm_pkg::action_t act,
			input logic signed [31:0] v);
		command_t c;
		c.act = act;
		c.val = v;
		pending_commands.push_back(c);
		if (act == dllm_pkg::ACT_INS_HEAD || act == dllm_pkg::ACT_INS_TAIL)
			inserted_values.push_back(v);
	endtask

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 7)) - 4;
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom());
		endcase
	endfunction

	// mostly values that were inserted earlier so deletes tend to hit
	function automatic logic signed [31:0] delete_target();
		if (inserted_values.size() > 0 && $urandom_range(0, 3) != 0)
			return inserted_values[$urandom_range(0, inserted_values.size() - 1)];
		return random_value();
	endfunction

	task automatic queue_random(input int count, input int ins_pct, input int del_pct);
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < ins_pct)
				queue_command($urandom_range(0, 1) ? dllm_pkg::ACT_INS_TAIL
					: dllm_pkg::ACT_INS_HEAD, random_value());
			else if (roll < ins_pct + del_pct)
				queue_command(dllm_pkg::ACT_DELETE, delete_target());
			else
				queue_command(dllm_pkg::ACT_TRAVERSE, $signed($urandom()));
		end
	endtask

	task automatic wait_drained();
		while (pending_commands.size() > 0 || in_valid || expected_responses.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		int room;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list cases, extremes, duplicates, head/tail order
		queue_command(dllm_pkg::ACT_TRAVERSE, 32'sh12345678);
		queue_command(dllm_pkg::ACT_DELETE, 32'sh80000000);
		queue_command(dllm_pkg::ACT_INS_HEAD, 32'sh7fffffff);
		queue_command(dllm_pkg::ACT_INS_TAIL, 32'sh80000000);
		queue_command(dllm_pkg::ACT_INS_HEAD, 32'sh0);
		queue_command(dllm_pkg::ACT_INS_TAIL, -32'sd1);
		queue_command(dllm_pkg::ACT_INS_HEAD, 32'sd5);
		queue_command(dllm_pkg::ACT_INS_TAIL, 32'sd5);
		queue_command(dllm_pkg::ACT_INS_TAIL, 32'shaaaaaaaa);
		queue_command(dllm_pkg::ACT_INS_HEAD, 32'sh55555555);
		queue_command(dllm_pkg::ACT_TRAVERSE, -32'sd1);
		queue_command(dllm_pkg::ACT_DELETE, 32'sd5);
		queue_command(dllm_pkg::ACT_TRAVERSE, 32'sh0);
		queue_command(dllm_pkg::ACT_DELETE, 32'sd12345);
		queue_command(dllm_pkg::ACT_DELETE, 32'sh80000000);
		queue_command(dllm_pkg::ACT_DELETE, 32'sh55555555);
		queue_command(dllm_pkg::ACT_DELETE, 32'sh7fffffff);
		queue_command(dllm_pkg::ACT_DELETE, 32'shaaaaaaaa);
		queue_command(dllm_pkg::ACT_DELETE, -32'sd1);
		queue_command(dllm_pkg::ACT_DELETE, 32'sd5);
		queue_command(dllm_pkg::ACT_DELETE, 32'sh0);
		queue_command(dllm_pkg::ACT_TRAVERSE, 32'sh7fffffff);
		queue_command(dllm_pkg::ACT_DELETE, 32'sh0);

		queue_random(40, 70, 15);

		// let everything come back before filling the pool
		wait_drained();
		room = DEPTH - list_contents.size();
		for (int i = 0; i < room + 2; i++)
			queue_command(i % 2 ? dllm_pkg::ACT_INS_TAIL : dllm_pkg::ACT_INS_HEAD,
				random_value());
		queue_command(dllm_pkg::ACT_TRAVERSE, '0);
		queue_command(dllm_pkg::ACT_DELETE, delete_target());
		queue_command(dllm_pkg::ACT_INS_TAIL, random_value());
		queue_command(dllm_pkg::ACT_INS_HEAD, random_value());
		queue_command(dllm_pkg::ACT_TRAVERSE, '0);

		queue_random(50, 25, 50);
		wait_drained();

		quiet = 1'b1;
		queue_random(25, 40, 35);
		wait_drained();
		repeat (40) @(negedge clk);

		$display("commands: %0d head inserts, %0d tail inserts, %0d deletes, %0d traverses",
			commands_by_action[dllm_pkg::ACT_INS_HEAD],
			commands_by_action[dllm_pkg::ACT_INS_TAIL],
			commands_by_action[dllm_pkg::ACT_DELETE],
			commands_by_action[dllm_pkg::ACT_TRAVERSE]);
		$display("%0d items checked, %0d list elements, pool full %0d times, deepest list %0d",
			responses_checked, elements_seen, full_hits, deepest);
		if (errors == 0 && expected_responses.size() == 0)
			$display("doubly_linked_list_manager_tb: clean");
		else
			$display("doubly_linked_list_manager_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
